>>> src/fsd_pkg.sv
// Shared constants and types for the fader smoothing and deadband block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fsd_pkg;

    // Default sizing, handed down from the top level
    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 10;

    // Fixed field widths
    localparam int CH_W       = 3;
    localparam int TIME_W     = 32;
    localparam int POS_W      = 8;
    localparam int INTERVAL_W = 16;
    localparam int DEADBAND_W = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_READ_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND      = 2'd1;

    // Reset values
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd10;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = 8'd2;
    localparam logic [POS_W-1:0]      POS_RESET      = 8'd255;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Live configuration seen by the back end
    typedef struct packed {
        logic [INTERVAL_W-1:0] read_interval;
        logic [DEADBAND_W-1:0] deadband;
    } cfg_t;

endpackage

>>> src/fsd_front.sv
// Front end: accepts input words, drops out-of-range channels, forms the index.
// Depends on fsd_pkg.
`timescale 1ns / 1ps

module fsd_front #(
    parameter int CHANNELS    = fsd_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = fsd_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fsd_pkg::CH_W-1:0]     s_channel,
    input  logic [SAMPLE_BITS-1:0]       s_sample,
    input  logic [fsd_pkg::TIME_W-1:0]   s_time_ms,
    output logic                         q_valid,
    input  logic                         q_ready,
    output logic [IDX_W-1:0]             q_idx,
    output logic [fsd_pkg::CH_W-1:0]     q_channel,
    output logic [SAMPLE_BITS-1:0]       q_sample,
    output logic [fsd_pkg::TIME_W-1:0]   q_time
);
    import fsd_pkg::*;

    localparam int WIDE_W = (IDX_W > CH_W) ? IDX_W : CH_W;

    logic                  valid_reg;
    logic                  keep_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [CH_W-1:0]       channel_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [TIME_W-1:0]     time_reg;
    logic [WIDE_W-1:0]     ch_wide;
    logic                  in_range;
    logic                  take;

    // Classify the incoming channel
    assign ch_wide  = WIDE_W'(s_channel);
    assign in_range = (32'(s_channel) < 32'(CHANNELS));

    // Free the holding stage when empty, dropped, or moving into the queue
    assign s_ready = !valid_reg || !keep_reg || q_ready;
    assign take    = s_valid && s_ready;

    // Hold one word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            keep_reg    <= in_range;
            idx_reg     <= ch_wide[IDX_W-1:0];
            channel_reg <= s_channel;
            sample_reg  <= s_sample;
            time_reg    <= s_time_ms;
        end
    end

    assign q_valid   = valid_reg && keep_reg;
    assign q_idx     = idx_reg;
    assign q_channel = channel_reg;
    assign q_sample  = sample_reg;
    assign q_time    = time_reg;

endmodule

>>> src/fsd_queue.sv
// Short FIFO that decouples the front end from the back end.
// Depends on fsd_pkg for its depth.
`timescale 1ns / 1ps

module fsd_queue #(
    parameter int DATA_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);
    import fsd_pkg::*;

    logic [DATA_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_data  = mem_reg[rd_ptr_reg];

    // Track occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store words
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> src/fsd_back.sv
// Back end: interval check and averaging, position scaling, deadband compare.
// Depends on fsd_pkg; fed by fsd_queue, drives the result register.
`timescale 1ns / 1ps

module fsd_back #(
    parameter int CHANNELS    = fsd_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = fsd_pkg::SAMPLE_BITS_DEF,
    parameter int IDX_W       = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fsd_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [IDX_W-1:0]              in_idx,
    input  logic [fsd_pkg::CH_W-1:0]      in_channel,
    input  logic [SAMPLE_BITS-1:0]        in_sample,
    input  logic [fsd_pkg::TIME_W-1:0]    in_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fsd_pkg::CH_W-1:0]      m_out_channel,
    output logic [fsd_pkg::POS_W-1:0]     m_position
);
    import fsd_pkg::*;

    localparam int N = SAMPLE_BITS;
    localparam logic [N:0] SAMPLE_MAX = {1'b0, {N{1'b1}}};

    // Per-channel state
    logic [TIME_W-1:0] last_time_reg  [CHANNELS];
    logic [N-1:0]      smooth_reg     [CHANNELS];
    logic              smooth_ok_reg  [CHANNELS];
    logic [POS_W-1:0]  last_pos_reg   [CHANNELS];

    // Pipeline registers
    logic              b_valid_reg;
    logic [IDX_W-1:0]  b_idx_reg;
    logic [CH_W-1:0]   b_channel_reg;
    logic [N-1:0]      b_value_reg;
    logic              c_valid_reg;
    logic [IDX_W-1:0]  c_idx_reg;
    logic [CH_W-1:0]   c_channel_reg;
    logic [POS_W-1:0]  c_pos_reg;
    logic              m_valid_reg;
    logic [CH_W-1:0]   m_channel_reg;
    logic [POS_W-1:0]  m_pos_reg;

    logic              adv;
    logic [TIME_W-1:0] elapsed;
    logic              due;
    logic              hit;
    logic [N+1:0]      avg_sum;
    logic [N-1:0]      value_next;
    logic [N+7:0]      prod;
    logic [POS_W-1:0]  quot;
    logic [N:0]        rem;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  last_pos;
    logic [POS_W-1:0]  diff;
    logic              emit;

    // Whole back end moves unless a result is stuck at the output
    assign adv      = !m_valid_reg || m_ready;
    assign in_ready = adv;

    // Stage A: interval check and moving average
    assign elapsed = in_time - last_time_reg[in_idx];
    assign due     = (elapsed[TIME_W-1:INTERVAL_W] != '0)
                   || (elapsed[INTERVAL_W-1:0] >= cfg.read_interval);
    assign hit     = in_valid && adv && due;
    assign avg_sum = {1'b0, smooth_reg[in_idx], 1'b0} + {2'b00, smooth_reg[in_idx]}
                   + {2'b00, in_sample};
    assign value_next = smooth_ok_reg[in_idx] ? avg_sum[N+1:2] : in_sample;

    // Stage B: scale to 0..255 as v*255 / (2^N - 1), one correction step
    assign prod = {b_value_reg, 8'd0} - (N+8)'(b_value_reg);
    assign quot = prod[N+7:N];
    assign rem  = {1'b0, prod[N-1:0]} + (N+1)'(quot);
    assign pos_next = (rem >= SAMPLE_MAX) ? quot + 1'b1 : quot;

    // Stage C: deadband against the last sent position
    assign last_pos = last_pos_reg[c_idx_reg];
    assign diff     = (c_pos_reg >= last_pos) ? c_pos_reg - last_pos : last_pos - c_pos_reg;
    assign emit     = c_valid_reg && (diff > cfg.deadband);

    // Control state and reset-valued state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < CHANNELS; k++) begin
                last_time_reg[k] <= '0;
                smooth_ok_reg[k] <= 1'b0;
                last_pos_reg[k]  <= POS_RESET;
            end
        end else if (adv) begin
            b_valid_reg <= hit;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= emit;
            if (hit) begin
                last_time_reg[in_idx] <= in_time;
                smooth_ok_reg[in_idx] <= 1'b1;
            end
            if (emit) begin
                last_pos_reg[c_idx_reg] <= c_pos_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            if (hit) begin
                smooth_reg[in_idx] <= value_next;
            end
            b_idx_reg     <= in_idx;
            b_channel_reg <= in_channel;
            b_value_reg   <= value_next;
            c_idx_reg     <= b_idx_reg;
            c_channel_reg <= b_channel_reg;
            c_pos_reg     <= pos_next;
            if (emit) begin
                m_channel_reg <= c_channel_reg;
                m_pos_reg     <= c_pos_reg;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_channel_reg;
    assign m_position    = m_pos_reg;

endmodule

>>> src/fader_smoothing_deadband_top.sv
// A word passes the front register, a 4-word queue, a 3-stage back end (interval/average,
// scale, deadband). Throughput: one input word per cycle while results are taken; a held
// result stalls the back end and, once the queue fills, the front. Per-channel state updates
// within its stage, so words of one channel follow back to back. Reset (aresetn,
// synchronous, active low) clears channel times and average flags and sets last positions
// to 255, read interval to 10 and deadband to 2; words are taken once reset ends.
`timescale 1ns / 1ps

module fader_smoothing_deadband_top #(
    parameter int CHANNELS    = fsd_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = fsd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fsd_pkg::CH_W-1:0]        s_channel,
    input  logic [SAMPLE_BITS-1:0]          s_sample,
    input  logic [fsd_pkg::TIME_W-1:0]      s_time_ms,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fsd_pkg::CH_W-1:0]        m_out_channel,
    output logic [fsd_pkg::POS_W-1:0]       m_position,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fsd_pkg::*;

    localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DATA_W = IDX_W + CH_W + SAMPLE_BITS + TIME_W;

    cfg_t              cfg_reg;
    logic              f_valid;
    logic              f_ready;
    logic [IDX_W-1:0]  f_idx;
    logic [CH_W-1:0]   f_channel;
    logic [SAMPLE_BITS-1:0] f_sample;
    logic [TIME_W-1:0] f_time;
    logic [DATA_W-1:0] q_in_data;
    logic [DATA_W-1:0] q_out_data;
    logic              q_valid;
    logic              q_ready;
    logic [IDX_W-1:0]  b_idx;
    logic [CH_W-1:0]   b_channel;
    logic [SAMPLE_BITS-1:0] b_sample;
    logic [TIME_W-1:0] b_time;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.read_interval <= INTERVAL_RESET;
            cfg_reg.deadband      <= DEADBAND_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_READ_INTERVAL: cfg_reg.read_interval <= cfg_data[INTERVAL_W-1:0];
                REG_DEADBAND:      cfg_reg.deadband      <= cfg_data[DEADBAND_W-1:0];
                default: ;
            endcase
        end
    end

    fsd_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_channel (s_channel),
        .s_sample  (s_sample),
        .s_time_ms (s_time_ms),
        .q_valid   (f_valid),
        .q_ready   (f_ready),
        .q_idx     (f_idx),
        .q_channel (f_channel),
        .q_sample  (f_sample),
        .q_time    (f_time)
    );

    // Pack and unpack the queue word
    assign q_in_data = {f_idx, f_channel, f_sample, f_time};
    assign {b_idx, b_channel, b_sample, b_time} = q_out_data;

    fsd_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out_data)
    );

    fsd_back #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IDX_W       (IDX_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (q_valid),
        .in_ready      (q_ready),
        .in_idx        (b_idx),
        .in_channel    (b_channel),
        .in_sample     (b_sample),
        .in_time       (b_time),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_position    (m_position)
    );

endmodule
